// ===== rtl/core/longest_prefix_match_route_table_top_defines.svh =====
// Assertion macros used by the route table top level.
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("route table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("route table check failed");

`endif

// ===== rtl/core/lpm_pkg.sv =====
// Payload types, codes and helpers of the longest prefix match route table.
`default_nettype none

package lpm_pkg;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FORWARD = 3'd2;
    localparam logic [2:0] ST_LOCAL   = 3'd3;
    localparam logic [2:0] ST_DROP    = 3'd4;

    typedef struct packed {
        logic        command;
        logic [31:0] address;
        logic [31:0] route_mask;
        logic [15:0] hop_id;
        logic        deliver_local;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_hop_id;
        logic [5:0]  prefix_length;
        logic [5:0]  entry_index;
    } out_t;

    // Request token moving down the cell chain, with the best match so far.
    typedef struct packed {
        logic        vld;
        logic        cmd;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [15:0] hop;
        logic        dlv_local;
        logic        full;
        logic        found;
        logic [5:0]  best_len;
        logic [15:0] best_hop;
        logic        best_dlv;
    } tok_t;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    function automatic logic [5:0] mask_ones(input logic [31:0] m);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = {1'b0, byte_ones(m[7:0])} + {1'b0, byte_ones(m[15:8])};
        hi = {1'b0, byte_ones(m[23:16])} + {1'b0, byte_ones(m[31:24])};
        return {1'b0, lo} + {1'b0, hi};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpm_cell.sv =====
// One route cell: stores one route and passes the request token onward.
`default_nettype none

module lpm_cell #(
    parameter int TABLE_ENTRIES = 64,
    parameter int CELL_IDX      = 0
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            en,
    input  wire lpm_pkg::tok_t                                   in_tok,
    input  wire logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] in_pos,
    input  wire logic [$clog2(TABLE_ENTRIES + 1)-1:0]            in_cnt,
    output lpm_pkg::tok_t                                        out_tok,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] out_pos,
    output logic [$clog2(TABLE_ENTRIES + 1)-1:0]                 out_cnt
);
    import lpm_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] net_reg;
    logic [31:0] mask_reg;
    logic [15:0] hop_reg;
    logic        dlv_reg;
    logic [5:0]  len_reg;

    tok_t          tok_reg, tok_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg;

    logic wr_hit;
    logic in_use;
    logic hit;

    assign wr_hit = in_tok.vld && (in_tok.cmd == CMD_ADD) && !in_tok.full
                    && (in_pos == IW'(CELL_IDX));
    assign in_use = CW'(CELL_IDX) < in_cnt;
    assign hit    = in_tok.vld && (in_tok.cmd == CMD_LOOKUP) && in_use
                    && ((in_tok.addr & mask_reg) == (net_reg & mask_reg))
                    && (!in_tok.found || (len_reg > in_tok.best_len));

    always_comb begin
        tok_next = in_tok;
        pos_next = in_pos;
        if (hit) begin
            tok_next.found    = 1'b1;
            tok_next.best_len = len_reg;
            tok_next.best_hop = hop_reg;
            tok_next.best_dlv = dlv_reg;
            pos_next          = IW'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (en) begin
            tok_reg.vld <= tok_next.vld;
        end
        // Payload of the token and the stored route need no reset.
        if (en) begin
            tok_reg.cmd       <= tok_next.cmd;
            tok_reg.addr      <= tok_next.addr;
            tok_reg.mask      <= tok_next.mask;
            tok_reg.hop       <= tok_next.hop;
            tok_reg.dlv_local <= tok_next.dlv_local;
            tok_reg.full      <= tok_next.full;
            tok_reg.found     <= tok_next.found;
            tok_reg.best_len  <= tok_next.best_len;
            tok_reg.best_hop  <= tok_next.best_hop;
            tok_reg.best_dlv  <= tok_next.best_dlv;
            pos_reg           <= pos_next;
            cnt_reg           <= in_cnt;
            if (wr_hit) begin
                net_reg  <= in_tok.addr;
                mask_reg <= in_tok.mask;
                hop_reg  <= in_tok.hop;
                dlv_reg  <= in_tok.dlv_local;
                len_reg  <= mask_ones(in_tok.mask);
            end
        end
    end

    assign out_tok = tok_reg;
    assign out_pos = pos_reg;
    assign out_cnt = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/longest_prefix_match_route_table_top.sv =====
// Top level of the longest prefix match route table: cell chain and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_valid / s_ready  | s_data  (lpm_pkg::in_t)
//  m_      | out       | m_valid / m_ready  | m_data  (lpm_pkg::out_t)
//
// One transfer enters per cycle while the chain advances; its result passes
// through the register of each cell of the route chain, then the result register.
// Synchronous active-low reset empties the table and the chain; stored routes
// are not cleared, a lookup only consults cells below the count it carries.
// A held result (m_valid high, m_ready low) stalls the whole chain and drops
// s_ready; the chain resumes in the cycle that result is taken.
`default_nettype none

`include "longest_prefix_match_route_table_top_defines.svh"

module longest_prefix_match_route_table_top #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lpm_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lpm_pkg::out_t      m_data
);
    import lpm_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Tokens between cells: index 0 feeds the first cell, the last leaves the chain.
    tok_t          tok_w [0:TABLE_ENTRIES];
    logic [IW-1:0] pos_w [0:TABLE_ENTRIES];
    logic [CW-1:0] cnt_w [0:TABLE_ENTRIES];

    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg;
    out_t          m_data_reg, m_data_next;
    logic          advance;
    logic          s_xfer;
    logic          table_full;

    // Advance the chain whenever the result register is free or being drained.
    assign advance    = !m_valid_reg || m_ready;
    assign s_ready    = advance && aresetn;
    assign s_xfer     = s_valid && s_ready;
    assign table_full = (count_reg == CW'(TABLE_ENTRIES));

    // Build the entry token; the add position and the lookup bound come from the count.
    always_comb begin
        tok_w[0].vld       = s_xfer;
        tok_w[0].cmd       = s_data.command;
        tok_w[0].addr      = s_data.address;
        tok_w[0].mask      = s_data.route_mask;
        tok_w[0].hop       = s_data.hop_id;
        tok_w[0].dlv_local = s_data.deliver_local;
        tok_w[0].full      = table_full;
        tok_w[0].found     = 1'b0;
        tok_w[0].best_len  = 6'd0;
        tok_w[0].best_hop  = 16'd0;
        tok_w[0].best_dlv  = 1'b0;
        pos_w[0]           = IW'(count_reg);
        cnt_w[0]           = count_reg;
    end

    // Count routes at entry so later lookups see every earlier add.
    always_comb begin
        count_next = count_reg;
        if (s_xfer && (s_data.command == CMD_ADD) && !table_full) begin
            count_next = count_reg + CW'(1);
        end
    end

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        lpm_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_IDX      (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .in_tok  (tok_w[k]),
            .in_pos  (pos_w[k]),
            .in_cnt  (cnt_w[k]),
            .out_tok (tok_w[k+1]),
            .out_pos (pos_w[k+1]),
            .out_cnt (cnt_w[k+1])
        );
    end

    // Turn the token leaving the chain into a result item.
    always_comb begin
        m_data_next.status        = ST_DROP;
        m_data_next.out_hop_id    = 16'd0;
        m_data_next.prefix_length = 6'd0;
        m_data_next.entry_index   = 6'd0;
        priority if (tok_w[TABLE_ENTRIES].cmd == CMD_ADD) begin
            if (tok_w[TABLE_ENTRIES].full) begin
                m_data_next.status = ST_FULL;
            end else begin
                m_data_next.status      = ST_ADDED;
                m_data_next.entry_index = 6'(pos_w[TABLE_ENTRIES]);
            end
        end else if (!tok_w[TABLE_ENTRIES].found) begin
            m_data_next.status = ST_DROP;
        end else if (tok_w[TABLE_ENTRIES].best_dlv) begin
            m_data_next.status        = ST_LOCAL;
            m_data_next.prefix_length = tok_w[TABLE_ENTRIES].best_len;
            m_data_next.entry_index   = 6'(pos_w[TABLE_ENTRIES]);
        end else begin
            m_data_next.status        = ST_FORWARD;
            m_data_next.out_hop_id    = tok_w[TABLE_ENTRIES].best_hop;
            m_data_next.prefix_length = tok_w[TABLE_ENTRIES].best_len;
            m_data_next.entry_index   = 6'(pos_w[TABLE_ENTRIES]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (advance) begin
                m_valid_reg <= tok_w[TABLE_ENTRIES].vld;
            end
        end
    end

    // Hold the result payload while it waits for the sink.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The route count never passes the table size.
    `LPM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_ENTRIES))

    // A held result stalls the input side.
    `LPM_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid_reg && !m_ready, !s_ready)

    // An add into a full table stores nothing.
    `LPM_ASSERT_NEXT(a_full_add_keeps_count, aclk, aresetn, s_xfer && (s_data.command == CMD_ADD) && table_full, $stable(count_reg))

    // An add with room takes exactly one more position.
    `LPM_ASSERT_NEXT(a_add_bumps_count, aclk, aresetn, s_xfer && (s_data.command == CMD_ADD) && !table_full, count_reg == $past(count_reg) + CW'(1))

endmodule

`default_nettype wire
